FILE: sv/slcd_pkg.sv
package slcd_pkg;

   localparam int LINE_DEPTH   = 5;
   localparam int POS_W        = $clog2(LINE_DEPTH);
   localparam int MIN_LINE     = 3;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int REPLY_IDX_W  = 3;
   localparam int OK_LEN       = 3;
   localparam int ERR_LEN      = 6;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_PULSE   = 8'h70;
   localparam logic [7:0] CH_FLASH   = 8'h66;
   localparam logic [7:0] CH_RED     = 8'h72;
   localparam logic [7:0] CH_ORANGE  = 8'h6F;
   localparam logic [7:0] CH_GREEN   = 8'h67;
   localparam logic [7:0] CH_UP_O    = 8'h4F;
   localparam logic [7:0] CH_UP_K    = 8'h4B;
   localparam logic [7:0] CH_UP_E    = 8'h45;
   localparam logic [7:0] CH_UP_R    = 8'h52;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_ON    = 2'd1,
      MODE_PULSE = 2'd2,
      MODE_FLASH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      LAMP_NONE   = 2'd0,
      LAMP_RED    = 2'd1,
      LAMP_ORANGE = 2'd2,
      LAMP_GREEN  = 2'd3
   } lamp_type;

   typedef struct packed {
      logic     ok;
      lamp_type lamp;
      mode_type mode;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      cmd_type head;
   } queue_status_type;

   typedef struct packed {
      logic     valid;
      mode_type code;
   } mode_dec_type;

   function automatic mode_dec_type decode_mode(input logic [7:0] c);
      mode_dec_type d;
      d.valid = 1'b1;
      unique case (c)
         CH_ZERO:  d.code = MODE_OFF;
         CH_ONE:   d.code = MODE_ON;
         CH_PULSE: d.code = MODE_PULSE;
         CH_FLASH: d.code = MODE_FLASH;
         default: begin
            d.valid = 1'b0;
            d.code  = MODE_OFF;
         end
      endcase
      return d;
   endfunction

   function automatic lamp_type decode_lamp(input logic [7:0] c);
      lamp_type l;
      unique case (c)
         CH_RED:    l = LAMP_RED;
         CH_ORANGE: l = LAMP_ORANGE;
         CH_GREEN:  l = LAMP_GREEN;
         default:   l = LAMP_NONE;
      endcase
      return l;
   endfunction

   function automatic logic [7:0] reply_text(input logic ok,
                                             input logic [REPLY_IDX_W-1:0] idx);
      logic [7:0] c;
      if (ok) begin
         unique case (idx)
            3'd0:    c = CH_UP_O;
            3'd1:    c = CH_UP_K;
            default: c = CH_NEWLINE;
         endcase
      end else begin
         unique case (idx)
            3'd0:    c = CH_UP_E;
            3'd1:    c = CH_UP_R;
            3'd2:    c = CH_UP_R;
            3'd3:    c = CH_UP_O;
            3'd4:    c = CH_UP_R;
            default: c = CH_NEWLINE;
         endcase
      end
      return c;
   endfunction

endpackage

FILE: sv/slcd_front.sv
module slcd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_char,
   input  logic                queue_full,
   output slcd_pkg::push_type  push
);

   logic [slcd_pkg::POS_W-1:0] pos_ff, pos_in, pos_adv;
   logic [7:0]                 lamp_byte_ff, lamp_byte_in;
   logic [7:0]                 mode_byte_ff, mode_byte_in;
   logic                       accept;
   logic                       newline;
   slcd_pkg::mode_dec_type     mode_dec;
   slcd_pkg::lamp_type         lamp_dec;
   logic                       long_enough;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign newline   = (req_rx_char == slcd_pkg::CH_NEWLINE);

   always_comb begin
      if (pos_ff == slcd_pkg::POS_W'(slcd_pkg::LINE_DEPTH - 1)) begin
         pos_adv = '0;
      end else begin
         pos_adv = pos_ff + 1'b1;
      end
   end

   assign long_enough = (pos_adv >= slcd_pkg::POS_W'(slcd_pkg::MIN_LINE));
   assign mode_dec    = slcd_pkg::decode_mode(mode_byte_ff);
   assign lamp_dec    = slcd_pkg::decode_lamp(lamp_byte_ff);

   always_comb begin
      push.valid    = accept && newline;
      push.cmd.ok   = long_enough && mode_dec.valid && (lamp_dec != slcd_pkg::LAMP_NONE);
      push.cmd.lamp = lamp_dec;
      push.cmd.mode = mode_dec.code;
   end

   always_comb begin
      pos_in       = pos_ff;
      lamp_byte_in = lamp_byte_ff;
      mode_byte_in = mode_byte_ff;
      if (accept) begin
         pos_in = newline ? '0 : pos_adv;
         if (pos_ff == slcd_pkg::POS_W'(0)) begin
            lamp_byte_in = req_rx_char;
         end
         if (pos_ff == slcd_pkg::POS_W'(1)) begin
            mode_byte_in = req_rx_char;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         lamp_byte_ff <= '0;
         mode_byte_ff <= '0;
      end else begin
         pos_ff       <= pos_in;
         lamp_byte_ff <= lamp_byte_in;
         mode_byte_ff <= mode_byte_in;
      end
   end

endmodule

FILE: sv/slcd_queue.sv
module slcd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  slcd_pkg::push_type         push,
   input  logic                       pop,
   output slcd_pkg::queue_status_type status
);

   slcd_pkg::cmd_type               mem_ff [slcd_pkg::QUEUE_DEPTH];
   logic [slcd_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [slcd_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [slcd_pkg::QCOUNT_W-1:0]   count_ff, count_in;
   logic                            do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == slcd_pkg::QCOUNT_W'(slcd_pkg::QUEUE_DEPTH));
   assign status.head  = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !status.full;
   assign do_pop  = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == slcd_pkg::QPTR_W'(slcd_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/slcd_back.sv
module slcd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  slcd_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_reply_char,
   output logic                       rsp_reply_last,
   output logic [1:0]                 rsp_red_state,
   output logic [1:0]                 rsp_orange_state,
   output logic [1:0]                 rsp_green_state
);

   logic [slcd_pkg::REPLY_IDX_W-1:0] idx_ff, idx_in;
   logic                             valid_ff, valid_in;
   logic [7:0]                       char_ff;
   logic                             last_ff;
   logic [1:0]                       red_ff, red_in;
   logic [1:0]                       orange_ff, orange_in;
   logic [1:0]                       green_ff, green_in;
   logic                             load;
   logic                             last_byte;
   logic [slcd_pkg::REPLY_IDX_W-1:0] len_m1;
   slcd_pkg::cmd_type                cmd;

   assign cmd    = status.head;
   assign load   = !status.empty && (!valid_ff || !rsp_stall);
   assign len_m1 = cmd.ok ? slcd_pkg::REPLY_IDX_W'(slcd_pkg::OK_LEN - 1) :
                            slcd_pkg::REPLY_IDX_W'(slcd_pkg::ERR_LEN - 1);
   assign last_byte = (idx_ff == len_m1);
   assign pop       = load && last_byte;

   always_comb begin
      red_in    = red_ff;
      orange_in = orange_ff;
      green_in  = green_ff;
      if (cmd.ok) begin
         unique case (cmd.lamp)
            slcd_pkg::LAMP_RED:    red_in    = cmd.mode;
            slcd_pkg::LAMP_ORANGE: orange_in = cmd.mode;
            slcd_pkg::LAMP_GREEN:  green_in  = cmd.mode;
            default: ;
         endcase
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_byte ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
         red_ff    <= '0;
         orange_ff <= '0;
         green_ff  <= '0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         if (load) begin
            red_ff    <= red_in;
            orange_ff <= orange_in;
            green_ff  <= green_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= slcd_pkg::reply_text(cmd.ok, idx_ff);
         last_ff <= last_byte;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_reply_char   = char_ff;
   assign rsp_reply_last   = last_ff;
   assign rsp_red_state    = red_ff;
   assign rsp_orange_state = orange_ff;
   assign rsp_green_state  = green_ff;

endmodule

FILE: sv/serial_lamp_command_decoder_unit.sv
// channel | direction | word
// req     | in        | rx_char: one received byte, newline ends a command
// rsp     | out       | reply_char, reply_last, red/orange/green_state
//
// A byte is taken every cycle unless the two-entry command queue is full.
// A newline yields 3 reply words (OK) or 6 (ERROR), one per cycle from the back end's
// output register while rsp_stall is low; the reply receiver sets the sustained rate.
// Reset is synchronous; it clears the line position, stored bytes, queue and lamps.
// rsp_stall holds the back end only; the front keeps taking bytes until the queue fills.
module serial_lamp_command_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_char,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_reply_char,
   output logic       rsp_reply_last,
   output logic [1:0] rsp_red_state,
   output logic [1:0] rsp_orange_state,
   output logic [1:0] rsp_green_state
);

   slcd_pkg::push_type         push;
   slcd_pkg::queue_status_type status;
   logic                       pop;

   slcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_char (req_rx_char),
      .queue_full  (status.full),
      .push        (push)
   );

   slcd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   slcd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reply_char   (rsp_reply_char),
      .rsp_reply_last   (rsp_reply_last),
      .rsp_red_state    (rsp_red_state),
      .rsp_orange_state (rsp_orange_state),
      .rsp_green_state  (rsp_green_state)
   );

endmodule

FILE: sv/slcd_checker.sv
module slcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_reply_char,
   input logic       rsp_reply_last,
   input logic [1:0] rsp_red_state,
   input logic [1:0] rsp_orange_state,
   input logic [1:0] rsp_green_state
);

   logic rsp_take;
   assign rsp_take = rsp_valid && !rsp_stall;

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_reply_char)
                                    && $stable(rsp_reply_last)))
      else $error("stalled rsp word changed");

   a_last_newline: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reply_last) |-> (rsp_reply_char == slcd_pkg::CH_NEWLINE))
      else $error("final reply word is not newline");

   a_ok_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_reply_char == slcd_pkg::CH_UP_K) |=>
      (rsp_valid && rsp_reply_last && rsp_reply_char == slcd_pkg::CH_NEWLINE))
      else $error("OK reply not closed by newline");

   a_lamps_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_reply_last) |=> ($stable(rsp_red_state)
         && $stable(rsp_orange_state) && $stable(rsp_green_state)))
      else $error("lamp state changed inside a reply");

endmodule

bind serial_lamp_command_decoder_unit slcd_checker u_slcd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_reply_char   (rsp_reply_char),
   .rsp_reply_last   (rsp_reply_last),
   .rsp_red_state    (rsp_red_state),
   .rsp_orange_state (rsp_orange_state),
   .rsp_green_state  (rsp_green_state)
);

FILE: dv/tb_serial_lamp_command_decoder_unit.sv
module tb_serial_lamp_command_decoder_unit;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_BYTES = 105;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic [1:0] red;
      logic [1:0] orange;
      logic [1:0] green;
   } reply_word_type;

   class lamp_reply_board;
      logic [7:0]          line_buf [slcd_pkg::LINE_DEPTH];
      int unsigned         wr_pos;
      slcd_pkg::mode_type  red_m;
      slcd_pkg::mode_type  orange_m;
      slcd_pkg::mode_type  green_m;
      reply_word_type      replies_due [$];
      int unsigned         errors;
      int unsigned         bytes_seen;
      int unsigned         words_checked;
      int unsigned         lines_ok;
      int unsigned         lines_err;

      function new();
         foreach (line_buf[i]) line_buf[i] = 8'h00;
         wr_pos        = 0;
         red_m         = slcd_pkg::MODE_OFF;
         orange_m      = slcd_pkg::MODE_OFF;
         green_m       = slcd_pkg::MODE_OFF;
         errors        = 0;
         bytes_seen    = 0;
         words_checked = 0;
         lines_ok      = 0;
         lines_err     = 0;
      endfunction

      function int pending();
         return replies_due.size();
      endfunction

      task report(string msg);
         if (errors < 30) $display("MISMATCH: %s", msg);
         errors++;
      endtask

      function void queue_reply(bit ok);
         logic [7:0]     txt [slcd_pkg::ERR_LEN];
         int             n;
         reply_word_type w;
         if (ok) begin
            txt[0] = slcd_pkg::CH_UP_O;
            txt[1] = slcd_pkg::CH_UP_K;
            txt[2] = slcd_pkg::CH_NEWLINE;
            n = slcd_pkg::OK_LEN;
            lines_ok++;
         end else begin
            txt[0] = slcd_pkg::CH_UP_E;
            txt[1] = slcd_pkg::CH_UP_R;
            txt[2] = slcd_pkg::CH_UP_R;
            txt[3] = slcd_pkg::CH_UP_O;
            txt[4] = slcd_pkg::CH_UP_R;
            txt[5] = slcd_pkg::CH_NEWLINE;
            n = slcd_pkg::ERR_LEN;
            lines_err++;
         end
         for (int k = 0; k < n; k++) begin
            w.ch     = txt[k];
            w.last   = (k == n - 1);
            w.red    = red_m;
            w.orange = orange_m;
            w.green  = green_m;
            replies_due.push_back(w);
         end
      endfunction

      function void note_byte(logic [7:0] c);
         bit                 hit;
         bit                 m_ok;
         slcd_pkg::mode_type m;
         bytes_seen++;
         line_buf[wr_pos] = c;
         wr_pos = (wr_pos + 1) % slcd_pkg::LINE_DEPTH;
         if (c != slcd_pkg::CH_NEWLINE) return;
         hit  = 1'b0;
         m_ok = 1'b1;
         m    = slcd_pkg::MODE_OFF;
         if (wr_pos >= slcd_pkg::MIN_LINE) begin
            case (line_buf[1])
               slcd_pkg::CH_ZERO:  m = slcd_pkg::MODE_OFF;
               slcd_pkg::CH_ONE:   m = slcd_pkg::MODE_ON;
               slcd_pkg::CH_PULSE: m = slcd_pkg::MODE_PULSE;
               slcd_pkg::CH_FLASH: m = slcd_pkg::MODE_FLASH;
               default:            m_ok = 1'b0;
            endcase
            if (m_ok) begin
               case (line_buf[0])
                  slcd_pkg::CH_RED: begin
                     red_m = m;
                     hit   = 1'b1;
                  end
                  slcd_pkg::CH_ORANGE: begin
                     orange_m = m;
                     hit      = 1'b1;
                  end
                  slcd_pkg::CH_GREEN: begin
                     green_m = m;
                     hit     = 1'b1;
                  end
                  default: hit = 1'b0;
               endcase
            end
         end
         wr_pos = 0;
         queue_reply(hit);
      endfunction

      task check_word(logic [7:0] ch, logic last, logic [1:0] red, logic [1:0] orange,
                      logic [1:0] green);
         reply_word_type want;
         words_checked++;
         if (replies_due.size() == 0) begin
            report($sformatf("reply word %h with nothing expected", ch));
            return;
         end
         want = replies_due.pop_front();
         if (ch !== want.ch)
            report($sformatf("reply_char got %h want %h", ch, want.ch));
         if (last !== want.last)
            report($sformatf("reply_last got %b want %b on %h", last, want.last, want.ch));
         if (red !== want.red)
            report($sformatf("red_state got %0d want %0d", red, want.red));
         if (orange !== want.orange)
            report($sformatf("orange_state got %0d want %0d", orange, want.orange));
         if (green !== want.green)
            report($sformatf("green_state got %0d want %0d", green, want.green));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_char = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_reply_char;
   logic       rsp_reply_last;
   logic [1:0] rsp_red_state;
   logic [1:0] rsp_orange_state;
   logic [1:0] rsp_green_state;

   int unsigned     send_idle = 0;
   int unsigned     stall_pct = 0;
   int unsigned     cycles = 0;
   lamp_reply_board board = new();

   serial_lamp_command_decoder_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_char      (req_rx_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reply_char   (rsp_reply_char),
      .rsp_reply_last   (rsp_reply_last),
      .rsp_red_state    (rsp_red_state),
      .rsp_orange_state (rsp_orange_state),
      .rsp_green_state  (rsp_green_state)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycles, board.pending());
         $display("tb_serial_lamp_command_decoder_unit: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_reply_char, rsp_reply_last, rsp_red_state,
                          rsp_orange_state, rsp_green_state);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_char <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(b);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_lamp();
      case ($urandom_range(3))
         0:       return slcd_pkg::CH_RED;
         1:       return slcd_pkg::CH_ORANGE;
         2:       return slcd_pkg::CH_GREEN;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_mode();
      case ($urandom_range(4))
         0:       return slcd_pkg::CH_ZERO;
         1:       return slcd_pkg::CH_ONE;
         2:       return slcd_pkg::CH_PULSE;
         3:       return slcd_pkg::CH_FLASH;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_command();
      int pick;
      int extra;
      pick = int'($urandom_range(99));
      if (pick < 12) begin
         repeat ($urandom_range(1, 7)) send_byte(8'($urandom_range(255)));
         if ($urandom_range(1)) send_byte(slcd_pkg::CH_NEWLINE);
         return;
      end
      if (pick < 22) repeat (slcd_pkg::LINE_DEPTH) send_byte(8'($urandom_range(255)));
      send_byte(pick_lamp());
      send_byte(pick_mode());
      extra = ($urandom_range(9) < 7) ? 0 : int'($urandom_range(1, 3));
      repeat (extra) send_byte(8'($urandom_range(255)));
      send_byte(slcd_pkg::CH_NEWLINE);
   endtask

   initial begin
      int unsigned start;
      bit          paused;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle = 66;
               stall_pct = 0;
            end
            2: begin
               send_idle = 0;
               stall_pct = 66;
            end
            default: begin
               send_idle = 36;
               stall_pct = 36;
            end
         endcase
         if (ph == 0) begin
            send_text("r0\n");
            send_text("of\n");
            send_text("gp\n");
            send_text("\n");
            send_text("x1\n");
            send_text("rz\n");
            send_text("r1xy\n");
            send_byte(8'h00);
            send_byte(8'hFF);
            send_text("cdeg1\n");
         end
         start  = board.bytes_seen;
         paused = 1'b0;
         while (board.bytes_seen - start < PHASE_BYTES) begin
            send_command();
            if (!paused && board.bytes_seen - start >= PHASE_BYTES / 2) begin
               paused = 1'b1;
               drain_replies();
            end
         end
      end
      drain_replies();
      repeat (16) @(posedge clock);
      $display("covered %0d input bytes, %0d OK and %0d ERROR replies, %0d reply words checked",
               board.bytes_seen, board.lines_ok, board.lines_err, board.words_checked);
      $display("over four sender-idle and receiver-stall mixes, %0d mismatches", board.errors);
      if (board.errors == 0 && board.pending() == 0)
         $display("tb_serial_lamp_command_decoder_unit: done, clean");
      else
         $display("tb_serial_lamp_command_decoder_unit: done, errors");
      $finish;
   end

endmodule
